### hdl/mjq_pkg.sv
// Shared constants, types and rounding helpers for the minimum-jerk coefficient unit.
package mjq_pkg;

  localparam int IN_FRAC_DEFAULT   = 16;
  localparam int COEF_FRAC_DEFAULT = 24;

  localparam int InW    = 32;
  localparam int DurW   = 24;
  localparam int CoefW  = 48;
  localparam int QuoW   = 49;
  localparam int SmallW = 72;
  localparam int InDataW  = 6 * InW + DurW;
  localparam int OutDataW = 6 * CoefW;

  localparam logic [CoefW-1:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [CoefW-1:0] COEF_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DUR = 2'd1,
    STATUS_SAT      = 2'd2
  } status_e;

  typedef struct packed {
    logic             sat;
    logic [CoefW-1:0] val;
  } coef_sat_t;

  // Apply sign to a magnitude and clamp to the signed 48-bit range.
  function automatic coef_sat_t clamp(input logic neg, input logic [SmallW-1:0] mag,
                                      input logic ovf);
    coef_sat_t r;
    logic      over;
    over = ovf | (neg ? (mag > (SmallW'(COEF_MAX) + SmallW'(1)))
                      : (mag > SmallW'(COEF_MAX)));
    r.sat = over;
    if (over) begin
      r.val = neg ? COEF_MIN : COEF_MAX;
    end else begin
      r.val = neg ? (CoefW'(0) - mag[CoefW-1:0]) : mag[CoefW-1:0];
    end
    return r;
  endfunction

  // round(x * 2^up / 2^dn), ties away from zero, saturated.
  function automatic coef_sat_t scale_small(input logic signed [InW-1:0] x,
                                            input int up, input int dn);
    logic              neg;
    logic [InW:0]      mag;
    logic [SmallW-1:0] w;
    neg = x[InW-1];
    mag = neg ? ((InW+1)'(0) - {x[InW-1], x}) : {1'b0, x};
    w   = {{(SmallW-InW-1){1'b0}}, mag} << up;
    w   = (w + (SmallW'(1) << (dn - 1))) >> dn;
    return clamp(neg, w, 1'b0);
  endfunction

  // q2 = floor(2 * value): halve with round-up, then clamp.
  function automatic coef_sat_t round_sat(input logic neg, input logic ovf,
                                          input logic [QuoW-1:0] q2);
    logic [QuoW:0] t;
    t = {1'b0, q2} + (QuoW+1)'(1);
    return clamp(neg, SmallW'(t[QuoW:1]), ovf);
  endfunction

endpackage

### hdl/mjq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
module mjq_div #(
  parameter int DW = 72,
  parameter int XW = 111,
  parameter int SW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [XW-1:0]              x_i,
  input  logic [DW-1:0]              dv_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [mjq_pkg::QuoW-1:0]   quo_o,
  output logic                       ovf_o,
  output logic [SW-1:0]              side_o
);

  localparam int QW = mjq_pkg::QuoW;
  localparam int RW = XW - QW;
  localparam int CW = (RW > DW) ? RW : DW;

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] bits_q [QW+1];
  logic [DW-1:0] dv_q   [QW+1];
  logic [SW-1:0] side_q [QW+1];
  logic          ovf_q  [QW+1];
  logic          vld_q  [QW+1];

  logic [RW-1:0] top_d;
  logic          ovf_d;

  // quotient must fit QW bits: top part of x below the divisor
  assign top_d = x_i[XW-1:QW];
  assign ovf_d = CW'(top_d) >= CW'(dv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ovf_d ? '0 : DW'(top_d);
      bits_q[0] <= x_i[QW-1:0];
      dv_q[0]   <= dv_i;
      side_q[0] <= side_i;
      ovf_q[0]  <= ovf_d;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] shift_d;
    logic [DW:0] diff_d;
    logic        ge_d;

    assign shift_d = {rem_q[i-1], bits_q[i-1][QW-1]};
    assign ge_d    = shift_d >= {1'b0, dv_q[i-1]};
    assign diff_d  = shift_d - {1'b0, dv_q[i-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    // shift the next dividend bit out on top, the quotient bit in below
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge_d ? diff_d[DW-1:0] : shift_d[DW-1:0];
        bits_q[i] <= {bits_q[i-1][QW-2:0], ge_d};
        dv_q[i]   <= dv_q[i-1];
        side_q[i] <= side_q[i-1];
        ovf_q[i]  <= ovf_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = bits_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

### hdl/min_jerk_quintic_coefficients_unit.sv
// Top level: minimum-jerk quintic coefficients from boundary states and duration.
//
//  port group | dir | payload (low bit first)                                  | handshake
//  s_axis     | in  | start_pos,start_vel,start_acc,end_pos,end_vel,end_acc,duration | tvalid/tready
//  m_axis     | out | tdata coef0..coef5, tuser status                         | tvalid/tready
//
//  One word is accepted per cycle while s_axis_tready is high; its result passes 59 register
//  stages: the three parallel 50-stage restoring dividers (an overflow precheck, then one
//  quotient bit per stage) sit behind seven stages of split 24-bit multiplies and wide adds,
//  and are followed by a rounding stage and the output register.
//  Reset clears every valid bit, those of the output and skid registers included.
//  A stall on m_axis fills the skid register, then freezes the whole pipeline together.
module min_jerk_quintic_coefficients_unit #(
  parameter int IN_FRAC_BITS   = mjq_pkg::IN_FRAC_DEFAULT,
  parameter int COEF_FRAC_BITS = mjq_pkg::COEF_FRAC_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration
  input  logic [mjq_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // coef0, coef1, coef2, coef3, coef4, coef5
  output logic [mjq_pkg::OutDataW-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                    m_axis_tuser
);

  localparam int F   = IN_FRAC_BITS;
  localparam int C   = COEF_FRAC_BITS;
  localparam int CW  = mjq_pkg::CoefW;
  localparam int QW  = mjq_pkg::QuoW;
  localparam int EW  = (F + 34 > 58) ? F + 34 : 58;
  localparam int PW  = (2 * F + 35 > F + 59) ? 2 * F + 35 : F + 59;
  localparam int AW0 = (PW > EW + 25) ? PW : EW + 25;
  localparam int AW  = ((AW0 > 82) ? AW0 : 82) + 1;
  localparam int MW  = AW + 5;
  localparam int XW3 = MW + C;
  localparam int XW4 = MW + C + F;
  localparam int XW5 = MW + C + 2 * F;

  typedef struct packed {
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
    logic [CW-1:0] c2;
    logic          ssat;
    logic          zero;
  } side_t;

  localparam int SW3 = $bits(side_t) + 1;

  logic pipe_en;

  // ---------------- stage 1: differences, d^2, first products
  logic signed [31:0] p0_d, v0_d, a0_d, p1_d, v1_d, a1_d;
  logic        [23:0] dur_d;
  mjq_pkg::coef_sat_t k0_d, k1_d, k2_d;

  logic               v1_q;
  logic signed [32:0] dp1_q, dv1_q, da1_q;
  logic signed [31:0] a01_q;
  logic        [23:0] dur1_q;
  logic        [47:0] dd1_q;
  logic signed [56:0] v0d1_q, a0d1_q;
  side_t              side1_q;

  assign p0_d  = s_axis_tdata[31:0];
  assign v0_d  = s_axis_tdata[63:32];
  assign a0_d  = s_axis_tdata[95:64];
  assign p1_d  = s_axis_tdata[127:96];
  assign v1_d  = s_axis_tdata[159:128];
  assign a1_d  = s_axis_tdata[191:160];
  assign dur_d = s_axis_tdata[215:192];

  assign k0_d = mjq_pkg::scale_small(p0_d, C, F);
  assign k1_d = mjq_pkg::scale_small(v0_d, C, F);
  assign k2_d = mjq_pkg::scale_small(a0_d, C, F + 1);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dp1_q        <= 33'(p1_d) - 33'(p0_d);
      dv1_q        <= 33'(v1_d) - 33'(v0_d);
      da1_q        <= 33'(a1_d) - 33'(a0_d);
      a01_q        <= a0_d;
      dur1_q       <= dur_d;
      dd1_q        <= 48'(dur_d) * 48'(dur_d);
      v0d1_q       <= v0_d * $signed({1'b0, dur_d});
      a0d1_q       <= a0_d * $signed({1'b0, dur_d});
      side1_q.c0   <= k0_d.val;
      side1_q.c1   <= k1_d.val;
      side1_q.c2   <= k2_d.val;
      side1_q.ssat <= k0_d.sat | k1_d.sat | k2_d.sat;
      side1_q.zero <= (dur_d == '0);
    end
  end

  // ---------------- stage 2: split products by d, start of B0 and D*b1
  logic               v2_q;
  logic        [47:0] d3lo2_q, d3hi2_q;
  logic signed [56:0] a0d2lo2_q, a0d2hi2_q;
  logic signed [57:0] dad2lo2_q, dad2hi2_q;
  logic signed [EW-1:0] e2_q;
  logic signed [PW-1:0] p2_q;
  logic        [23:0] dur2_q;
  side_t              side2_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d3lo2_q   <= 48'(dd1_q[23:0]) * 48'(dur1_q);
      d3hi2_q   <= 48'(dd1_q[47:24]) * 48'(dur1_q);
      a0d2lo2_q <= a01_q * $signed({1'b0, dd1_q[23:0]});
      a0d2hi2_q <= a01_q * $signed({1'b0, dd1_q[47:24]});
      dad2lo2_q <= da1_q * $signed({1'b0, dd1_q[23:0]});
      dad2hi2_q <= da1_q * $signed({1'b0, dd1_q[47:24]});
      e2_q      <= (EW'(dv1_q) <<< F) - EW'(a0d1_q);
      p2_q      <= (PW'(dp1_q) <<< (2 * F + 1)) - (PW'(v0d1_q) <<< (F + 1));
      dur2_q    <= dur1_q;
      side2_q   <= side1_q;
    end
  end

  // ---------------- stage 3: join halves, multiply e by d
  logic               v3_q;
  logic        [71:0] d33_q;
  logic signed [AW-1:0] a0d23_q, d2b23_q;
  logic        [47:0] elo3_q;
  logic signed [EW:0] ehi3_q;
  logic signed [PW-1:0] p3_q;
  logic        [23:0] dur3_q;
  side_t              side3_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d33_q   <= 72'(d3lo2_q) + (72'(d3hi2_q) << 24);
      a0d23_q <= AW'(a0d2lo2_q) + (AW'(a0d2hi2_q) <<< 24);
      d2b23_q <= AW'(dad2lo2_q) + (AW'(dad2hi2_q) <<< 24);
      elo3_q  <= 48'(e2_q[23:0]) * 48'(dur2_q);
      ehi3_q  <= $signed(e2_q[EW-1:24]) * $signed({1'b0, dur2_q});
      p3_q    <= p2_q;
      dur3_q  <= dur2_q;
      side3_q <= side2_q;
    end
  end

  // ---------------- stage 4: B0, D*b1, d^4 partials
  logic               v4_q;
  logic signed [AW-1:0] b04_q, db14_q, d2b24_q;
  logic        [47:0] d4p04_q, d4p14_q, d4p24_q;
  logic        [71:0] d34_q;
  logic        [23:0] dur4_q;
  side_t              side4_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b04_q   <= AW'(p3_q) - a0d23_q;
      db14_q  <= AW'($signed({1'b0, elo3_q})) + (AW'(ehi3_q) <<< 24);
      d2b24_q <= d2b23_q;
      d4p04_q <= 48'(d33_q[23:0]) * 48'(dur3_q);
      d4p14_q <= 48'(d33_q[47:24]) * 48'(dur3_q);
      d4p24_q <= 48'(d33_q[71:48]) * 48'(dur3_q);
      d34_q   <= d33_q;
      dur4_q  <= dur3_q;
      side4_q <= side3_q;
    end
  end

  // ---------------- stage 5: numerators, d^4
  logic               v5_q;
  logic signed [MW-1:0] m35_q, m45_q, m55_q;
  logic        [95:0] d45_q;
  logic        [71:0] d35_q;
  logic        [23:0] dur5_q;
  side_t              side5_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m35_q   <= MW'(b04_q) * 10 - MW'(db14_q) * 8 + MW'(d2b24_q);
      m45_q   <= MW'(db14_q) * 14 - MW'(b04_q) * 15 - MW'(d2b24_q) * 2;
      m55_q   <= MW'(b04_q) * 6 - MW'(db14_q) * 6 + MW'(d2b24_q);
      d45_q   <= 96'(d4p04_q) + (96'(d4p14_q) << 24) + (96'(d4p24_q) << 48);
      d35_q   <= d34_q;
      dur5_q  <= dur4_q;
      side5_q <= side4_q;
    end
  end

  // ---------------- stage 6: magnitudes, d^5 partials
  logic               v6_q;
  logic        [MW-1:0] mag36_q, mag46_q, mag56_q;
  logic               n36_q, n46_q, n56_q;
  logic        [47:0] d5p06_q, d5p16_q, d5p26_q, d5p36_q;
  logic        [95:0] d46_q;
  logic        [71:0] d36_q;
  side_t              side6_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      n36_q   <= m35_q[MW-1];
      n46_q   <= m45_q[MW-1];
      n56_q   <= m55_q[MW-1];
      mag36_q <= m35_q[MW-1] ? (MW'(0) - m35_q) : m35_q;
      mag46_q <= m45_q[MW-1] ? (MW'(0) - m45_q) : m45_q;
      mag56_q <= m55_q[MW-1] ? (MW'(0) - m55_q) : m55_q;
      d5p06_q <= 48'(d45_q[23:0]) * 48'(dur5_q);
      d5p16_q <= 48'(d45_q[47:24]) * 48'(dur5_q);
      d5p26_q <= 48'(d45_q[71:48]) * 48'(dur5_q);
      d5p36_q <= 48'(d45_q[95:72]) * 48'(dur5_q);
      d46_q   <= d45_q;
      d36_q   <= d35_q;
      side6_q <= side5_q;
    end
  end

  // ---------------- stage 7: d^5
  logic               v7_q;
  logic        [MW-1:0] mag37_q, mag47_q, mag57_q;
  logic               n37_q, n47_q, n57_q;
  logic        [119:0] d57_q;
  logic        [95:0] d47_q;
  logic        [71:0] d37_q;
  side_t              side7_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d57_q   <= 120'(d5p06_q) + (120'(d5p16_q) << 24) + (120'(d5p26_q) << 48)
               + (120'(d5p36_q) << 72);
      d47_q   <= d46_q;
      d37_q   <= d36_q;
      mag37_q <= mag36_q;
      mag47_q <= mag46_q;
      mag57_q <= mag56_q;
      n37_q   <= n36_q;
      n47_q   <= n46_q;
      n57_q   <= n56_q;
      side7_q <= side6_q;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // ---------------- dividers
  logic              dv_valid;
  logic [QW-1:0]     q3, q4, q5;
  logic              o3, o4, o5;
  logic [SW3-1:0]    s3_out;
  logic              s4_out, s5_out;
  side_t             side_fin;

  mjq_div #(.DW(72), .XW(XW3), .SW(SW3)) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v7_q),
    .x_i     (XW3'(mag37_q) << C),
    .dv_i    (d37_q),
    .side_i  ({side7_q, n37_q}),
    .valid_o (dv_valid),
    .quo_o   (q3),
    .ovf_o   (o3),
    .side_o  (s3_out)
  );

  mjq_div #(.DW(96), .XW(XW4), .SW(1)) u_div4 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v7_q),
    .x_i     (XW4'(mag47_q) << (C + F)),
    .dv_i    (d47_q),
    .side_i  (n47_q),
    .valid_o (),
    .quo_o   (q4),
    .ovf_o   (o4),
    .side_o  (s4_out)
  );

  mjq_div #(.DW(120), .XW(XW5), .SW(1)) u_div5 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v7_q),
    .x_i     (XW5'(mag57_q) << (C + 2 * F)),
    .dv_i    (d57_q),
    .side_i  (n57_q),
    .valid_o (),
    .quo_o   (q5),
    .ovf_o   (o5),
    .side_o  (s5_out)
  );

  // ---------------- final stage: round, clamp, status
  mjq_pkg::coef_sat_t r3_d, r4_d, r5_d;
  logic [mjq_pkg::OutDataW-1:0] word_d;
  mjq_pkg::status_e             stat_d;

  assign side_fin = s3_out[SW3-1:1];
  assign r3_d = mjq_pkg::round_sat(s3_out[0], o3, q3);
  assign r4_d = mjq_pkg::round_sat(s4_out, o4, q4);
  assign r5_d = mjq_pkg::round_sat(s5_out, o5, q5);

  always_comb begin
    if (side_fin.zero) begin
      word_d = '0;
      stat_d = mjq_pkg::STATUS_ZERO_DUR;
    end else begin
      word_d = {r5_d.val, r4_d.val, r3_d.val, side_fin.c2, side_fin.c1, side_fin.c0};
      stat_d = (side_fin.ssat | r3_d.sat | r4_d.sat | r5_d.sat) ? mjq_pkg::STATUS_SAT
                                                                : mjq_pkg::STATUS_OK;
    end
  end

  logic                         fin_v_q;
  logic [mjq_pkg::OutDataW-1:0] fin_word_q;
  mjq_pkg::status_e             fin_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (pipe_en) begin
      fin_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fin_word_q <= word_d;
      fin_stat_q <= stat_d;
    end
  end

  // ---------------- output register with skid
  logic                         out_v_q, skid_v_q;
  logic [mjq_pkg::OutDataW-1:0] out_word_q, skid_word_q;
  mjq_pkg::status_e             out_stat_q, skid_stat_q;
  logic                         take, emerge;

  assign pipe_en = !skid_v_q;
  assign take    = out_v_q && m_axis_tready;
  assign emerge  = fin_v_q && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= emerge;
      end
    end else if (!out_v_q) begin
      out_v_q <= emerge;
    end else if (emerge) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_v_q) begin
      out_word_q <= skid_word_q;
      out_stat_q <= skid_stat_q;
    end else if (take || !out_v_q) begin
      out_word_q <= fin_word_q;
      out_stat_q <= fin_stat_q;
    end
    // park the emerging word while the output holds
    if (!take && out_v_q && emerge) begin
      skid_word_q <= fin_word_q;
      skid_stat_q <= fin_stat_q;
    end
  end

  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

### hdl/mjq_chk.sv
// Port-level checker for the minimum-jerk coefficient unit, bound to the top level.
module mjq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [mjq_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mjq_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_zero_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == mjq_pkg::STATUS_ZERO_DUR |-> m_axis_tdata == '0)
    else $error("zero duration with nonzero coefficients");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

endmodule

bind min_jerk_quintic_coefficients_unit mjq_chk u_mjq_chk (.*);

### bench/testbench.sv
// Self-checking bench for the minimum-jerk coefficient unit: directed and random stream traffic, scoreboard.
module testbench;

  localparam int NUM_RANDOM  = 1530;
  localparam int CALM_TAIL   = 200;
  localparam int PAUSE_AT    = 700;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 120;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [mjq_pkg::DurW-1:0]       duration;
    logic signed [mjq_pkg::InW-1:0] end_acc;
    logic signed [mjq_pkg::InW-1:0] end_vel;
    logic signed [mjq_pkg::InW-1:0] end_pos;
    logic signed [mjq_pkg::InW-1:0] start_acc;
    logic signed [mjq_pkg::InW-1:0] start_vel;
    logic signed [mjq_pkg::InW-1:0] start_pos;
  } plan_req_t;

  typedef struct packed {
    mjq_pkg::status_e          status;
    logic [mjq_pkg::CoefW-1:0] c5;
    logic [mjq_pkg::CoefW-1:0] c4;
    logic [mjq_pkg::CoefW-1:0] c3;
    logic [mjq_pkg::CoefW-1:0] c2;
    logic [mjq_pkg::CoefW-1:0] c1;
    logic [mjq_pkg::CoefW-1:0] c0;
  } coef_set_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [mjq_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [mjq_pkg::OutDataW-1:0] m_axis_tdata;
  logic [1:0]                   m_axis_tuser;

  min_jerk_quintic_coefficients_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  plan_req_t pending_reqs[$];
  coef_set_t expected_coefs[$];
  int        total_reqs;
  int        sent_cnt;
  int        recv_cnt;
  int        error_cnt;
  int        sat_cnt;
  int        zero_cnt;

  // round(num * 2^sh / den), ties away from zero, clamped to 48 bits
  function automatic logic [mjq_pkg::CoefW-1:0] scaled_quotient(input wide_t num,
                                                                input int sh,
                                                                input logic [255:0] den,
                                                                output logic sat_o);
    logic           neg;
    logic [255:0]   mag;
    logic [255:0]   q;
    logic [255:0]   r;
    neg   = num < 0;
    mag   = neg ? -num : num;
    mag   = mag << sh;
    q     = mag / den;
    r     = mag - q * den;
    sat_o = 1'b0;
    if ((r << 1) >= den) q = q + 1;
    if (!neg && q > 256'(mjq_pkg::COEF_MAX)) begin
      sat_o = 1'b1;
      return mjq_pkg::COEF_MAX;
    end
    if (neg && q > 256'(mjq_pkg::COEF_MIN)) begin
      sat_o = 1'b1;
      return mjq_pkg::COEF_MIN;
    end
    return neg ? (mjq_pkg::CoefW'(0) - q[mjq_pkg::CoefW-1:0]) : q[mjq_pkg::CoefW-1:0];
  endfunction

  function automatic coef_set_t plan_coefs(input plan_req_t rq);
    coef_set_t     res;
    wide_t         p0, v0, a0, p1, v1, a1, t, bpos, bvel, bacc;
    logic [255:0]  den;
    logic          s0, s1, s2, s3, s4, s5;
    res = '0;
    if (rq.duration == '0) begin
      res.status = mjq_pkg::STATUS_ZERO_DUR;
      return res;
    end
    p0 = wide_t'(rq.start_pos);
    v0 = wide_t'(rq.start_vel);
    a0 = wide_t'(rq.start_acc);
    p1 = wide_t'(rq.end_pos);
    v1 = wide_t'(rq.end_vel);
    a1 = wide_t'(rq.end_acc);
    t  = wide_t'({1'b0, rq.duration});
    bpos = ((p1 - p0) <<< 33) - ((v0 * t) <<< 17) - a0 * t * t;
    bvel = (((v1 - v0) <<< 16) - a0 * t) * t;
    bacc = (a1 - a0) * t * t;
    res.c0 = scaled_quotient(p0, mjq_pkg::COEF_FRAC_DEFAULT, 256'(1) << 16, s0);
    res.c1 = scaled_quotient(v0, mjq_pkg::COEF_FRAC_DEFAULT, 256'(1) << 16, s1);
    res.c2 = scaled_quotient(a0, mjq_pkg::COEF_FRAC_DEFAULT, 256'(1) << 17, s2);
    den = 256'(2) * t * t * t;
    res.c3 = scaled_quotient(10 * bpos - 8 * bvel + bacc, mjq_pkg::COEF_FRAC_DEFAULT, den,
                             s3);
    den = den * t;
    res.c4 = scaled_quotient(-15 * bpos + 14 * bvel - 2 * bacc,
                             mjq_pkg::COEF_FRAC_DEFAULT + 16, den, s4);
    den = den * t;
    res.c5 = scaled_quotient(6 * bpos - 6 * bvel + bacc, mjq_pkg::COEF_FRAC_DEFAULT + 32,
                             den, s5);
    res.status = (s0 | s1 | s2 | s3 | s4 | s5) ? mjq_pkg::STATUS_SAT : mjq_pkg::STATUS_OK;
    return res;
  endfunction

  function automatic logic signed [mjq_pkg::InW-1:0] rand_span(input int bits);
    return $signed($urandom_range(0, (32'd1 << (bits + 1)) - 1)) - (32'sd1 <<< bits);
  endfunction

  function automatic plan_req_t rand_req();
    plan_req_t rq;
    int        pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      // plausible maneuver: moderate states, T between a quarter and sixteen seconds
      rq.start_pos = rand_span(24);
      rq.end_pos   = rand_span(24);
      rq.start_vel = rand_span(20);
      rq.end_vel   = rand_span(20);
      rq.start_acc = rand_span(18);
      rq.end_acc   = rand_span(18);
      rq.duration  = mjq_pkg::DurW'($urandom_range(32'h4000, 32'h10_0000));
    end else if (pick < 8) begin
      rq.start_pos = $urandom();
      rq.start_vel = $urandom();
      rq.start_acc = $urandom();
      rq.end_pos   = $urandom();
      rq.end_vel   = $urandom();
      rq.end_acc   = $urandom();
      rq.duration  = mjq_pkg::DurW'($urandom());
    end else begin
      rq.start_pos = rand_span(12);
      rq.end_pos   = rand_span(12);
      rq.start_vel = rand_span(10);
      rq.end_vel   = rand_span(10);
      rq.start_acc = rand_span(8);
      rq.end_acc   = rand_span(8);
      rq.duration  = mjq_pkg::DurW'($urandom_range(0, 255));
    end
    return rq;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    plan_req_t rq;
    rst_ni = 1'b0;
    // directed: zero duration, tiny and full T, field extremes, a rest-to-rest move
    rq = '0;
    pending_reqs.push_back(rq);
    rq = '1;
    rq.duration = '0;
    pending_reqs.push_back(rq);
    rq = '0;
    rq.end_pos = 32'sh0001_0000;
    rq.duration = 24'h01_0000;
    pending_reqs.push_back(rq);
    rq.duration = 24'h00_0001;
    pending_reqs.push_back(rq);
    rq.duration = 24'hFF_FFFF;
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'hFF_FFFF), {6{32'sh7FFF_FFFF}}};
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'hFF_FFFF), {6{32'sh8000_0000}}};
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'h00_0001), {6{32'sh8000_0000}}};
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'h00_0001), {6{32'sh7FFF_FFFF}}};
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'h02_0000), 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'h01_0000), 32'sh0000_0000, 32'sh0000_0000, 32'sh0050_0000,
          32'shFFFF_0000, 32'sh0001_0000, 32'shFFF0_0000};
    pending_reqs.push_back(rq);
    rq = {mjq_pkg::DurW'(24'h80_0000), 32'sh0002_0000, 32'shFFFE_0000, 32'sh0000_0001,
          32'sh0000_8000, 32'shFFFF_8000, 32'shFFFF_FFFF};
    pending_reqs.push_back(rq);
    for (int i = 0; i < 6; i++) begin
      rq = '0;
      rq.duration = 24'h00_8000;
      rq[i*mjq_pkg::InW +: mjq_pkg::InW] = 32'sh8000_0000;
      pending_reqs.push_back(rq);
      rq[i*mjq_pkg::InW +: mjq_pkg::InW] = 32'sh7FFF_FFFF;
      pending_reqs.push_back(rq);
    end
    for (int i = 0; i < NUM_RANDOM; i++) pending_reqs.push_back(rand_req());
    total_reqs = pending_reqs.size();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  int tx_idle;
  always @(posedge clk_i or negedge rst_ni) begin
    logic      next_valid;
    logic      took;
    int        idle_next;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      sent_cnt      <= 0;
      tx_idle       <= 0;
      sat_cnt       <= 0;
      zero_cnt      <= 0;
    end else begin
      took      = s_axis_tvalid && s_axis_tready;
      idle_next = tx_idle;
      if (took) begin
        expected_coefs.push_back(plan_coefs(pending_reqs.pop_front()));
        if (plan_coefs(s_axis_tdata).status == mjq_pkg::STATUS_SAT) sat_cnt <= sat_cnt + 1;
        if (s_axis_tdata[mjq_pkg::InDataW-1 -: mjq_pkg::DurW] == '0) zero_cnt <= zero_cnt + 1;
        sent_cnt <= sent_cnt + 1;
      end
      next_valid = 1'b0;
      if (s_axis_tvalid && !took) begin
        // keep offering a word until it is taken
        next_valid = 1'b1;
      end else if (idle_next > 0) begin
        idle_next = idle_next - 1;
      end else if (pending_reqs.size() > 0) begin
        // hold off once until the pipeline has drained completely
        if ((sent_cnt + (took ? 1 : 0)) == PAUSE_AT && expected_coefs.size() > 0) begin
          next_valid = 1'b0;
        end else if (sent_cnt < total_reqs - CALM_TAIL && $urandom_range(0, 7) == 0) begin
          idle_next = $urandom_range(0, 3);
        end else begin
          next_valid = 1'b1;
        end
      end
      tx_idle       <= idle_next;
      s_axis_tvalid <= next_valid;
      if (next_valid) s_axis_tdata <= pending_reqs[0];
    end
  end

  // monitor
  int rx_idle;
  int hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    coef_set_t want;
    coef_set_t got;
    int        idle_next;
    int        hold_next;
    logic      rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_idle       <= 0;
      hold_left     <= 0;
      recv_cnt      <= 0;
      error_cnt     <= 0;
    end else begin
      idle_next = rx_idle;
      hold_next = hold_left;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {mjq_pkg::status_e'(m_axis_tuser), m_axis_tdata};
        if (expected_coefs.size() == 0) begin
          $display("%0t: unexpected word coefs=%h status=%0d", $time, m_axis_tdata,
                   m_axis_tuser);
          error_cnt <= error_cnt + 1;
        end else begin
          want = expected_coefs.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (got[k*mjq_pkg::CoefW +: mjq_pkg::CoefW] !==
                want[k*mjq_pkg::CoefW +: mjq_pkg::CoefW]) begin
              $display("%0t: word %0d coef%0d expected %h actual %h", $time, recv_cnt, k,
                       want[k*mjq_pkg::CoefW +: mjq_pkg::CoefW],
                       got[k*mjq_pkg::CoefW +: mjq_pkg::CoefW]);
              error_cnt <= error_cnt + 1;
            end
          end
          if (got.status !== want.status) begin
            $display("%0t: word %0d status expected %0d actual %0d", $time, recv_cnt,
                     want.status, got.status);
            error_cnt <= error_cnt + 1;
          end
        end
        recv_cnt <= recv_cnt + 1;
        if (recv_cnt + 1 == HOLD_AT) hold_next = HOLD_CYCLES;
      end
      rdy = 1'b0;
      if (hold_next > 0) begin
        hold_next = hold_next - 1;
      end else if (idle_next > 0) begin
        idle_next = idle_next - 1;
      end else if (recv_cnt < total_reqs - CALM_TAIL && $urandom_range(0, 7) == 0) begin
        idle_next = $urandom_range(0, 3);
      end else begin
        rdy = 1'b1;
      end
      rx_idle       <= idle_next;
      hold_left     <= hold_next;
      m_axis_tready <= rdy;
    end
  end

  // watchdog: abort when no word moves for too long
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: stalled, %0d results outstanding", $time, expected_coefs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (pending_reqs.size() > 0 || expected_coefs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Planned %0d trajectories (%0d zero-duration, %0d saturating), checked %0d.",
             sent_cnt, zero_cnt, sat_cnt, recv_cnt);
    $display("Traffic mixed random stalls, one long output hold and one full drain.");
    if (error_cnt == 0 && expected_coefs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
